### design/vde_pkg.sv
`default_nettype none

package vde_pkg;

    // Field widths of the streaming interface.
    localparam int DATA_W      = 32;
    localparam int DIST_W      = 32;
    localparam int FRAC_BITS   = 16;

    // Number of low coordinate bits that take part; sign bit is COORD_WIDTH-1.
    localparam int COORD_WIDTH = 32;

    // Accumulator and square root sizing.
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);

    typedef enum logic [1:0] {
        MODE_EUCLID    = 2'd0,
        MODE_MANHATTAN = 2'd1,
        MODE_HAMMING   = 2'd2,
        MODE_UNDEF     = 2'd3
    } vde_mode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] coord_a;
        logic signed [DATA_W-1:0] coord_b;
        logic                     last_element;
    } vde_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } vde_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mag_en;
        logic term_en;
        logic acc_en;
        logic root_load;
        logic root_step;
        logic out_load;
    } vde_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic      item_last;
        vde_mode_t item_mode;
    } vde_stat_t;

endpackage

`default_nettype wire

### design/vde_datapath.sv
`default_nettype none

module vde_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [1:0]      cfg_wr_data,
    input  wire vde_pkg::vde_in_t  in_data,
    input  wire vde_pkg::vde_cmd_t cmd,
    output vde_pkg::vde_stat_t     stat,
    output vde_pkg::vde_out_t      out_data
);
    import vde_pkg::*;

    vde_mode_t               mode_reg;
    vde_mode_t               item_mode_reg;
    logic                    item_last_reg;
    logic [COORD_WIDTH-1:0]  a_reg;
    logic [COORD_WIDTH-1:0]  b_reg;
    logic [COORD_WIDTH-1:0]  mag_reg;
    logic [COORD_WIDTH-1:0]  mag_next;
    logic [SUM_W-1:0]        term_reg;
    logic [SUM_W-1:0]        term_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic [SUM_W-1:0]        x_reg;
    logic [ROOT_W+1:0]       rem_reg;
    logic [ROOT_W+1:0]       rem_next;
    logic [ROOT_W-1:0]       root_reg;
    logic [ROOT_W-1:0]       root_next;
    vde_out_t                out_reg;
    vde_out_t                out_next;

    logic [COORD_WIDTH:0]    diff;
    logic [COORD_WIDTH:0]    diff_neg;
    logic [2*COORD_WIDTH-1:0] square;
    logic [SUM_W:0]          sum_wide;
    logic [ROOT_W+1:0]       rem_shift;
    logic [ROOT_W+1:0]       trial;

    // Magnitude of the sign-extended difference.
    always_comb
    begin
        diff     = {a_reg[COORD_WIDTH-1], a_reg} - {b_reg[COORD_WIDTH-1], b_reg};
        diff_neg = -diff;
        mag_next = diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
    end

    // Term to add, chosen by the mode in force for this item.
    always_comb
    begin
        square = {{COORD_WIDTH{1'b0}}, mag_reg} * {{COORD_WIDTH{1'b0}}, mag_reg};
        unique case (item_mode_reg)
            MODE_EUCLID:    term_next = SUM_W'(square);
            MODE_MANHATTAN: term_next = SUM_W'(mag_reg);
            MODE_HAMMING:   term_next = SUM_W'(mag_reg != '0);
            MODE_UNDEF:     term_next = '0;
            default:        term_next = '0;
        endcase
    end

    // Saturating accumulate.
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + {1'b0, term_reg};
        sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        ovf_next = ovf_reg | sum_wide[SUM_W];
    end

    // One bit of the restoring square root per step.
    always_comb
    begin
        rem_shift = {rem_reg[ROOT_W-1:0], x_reg[SUM_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Final conversion to unsigned Q16.16.
    always_comb
    begin
        unique case (item_mode_reg)
            MODE_EUCLID:
            begin
                out_next.saturated = ovf_reg;
                out_next.distance  = root_reg;
            end
            MODE_MANHATTAN:
            begin
                out_next.saturated = ovf_reg | (sum_reg[SUM_W-1:DIST_W] != '0);
                out_next.distance  = sum_reg[DIST_W-1:0];
            end
            MODE_HAMMING:
            begin
                out_next.saturated = ovf_reg | (sum_reg[SUM_W-1:DIST_W-FRAC_BITS] != '0);
                out_next.distance  = {sum_reg[DIST_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
            end
            default:
            begin
                out_next.saturated = 1'b0;
                out_next.distance  = '0;
            end
        endcase
        if (out_next.saturated)
        begin
            out_next.distance = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EUCLID;
            sum_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= vde_mode_t'(cfg_wr_data);
            end
            if (cmd.out_load)
            begin
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.acc_en)
            begin
                sum_reg <= sum_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg         <= in_data.coord_a[COORD_WIDTH-1:0];
            b_reg         <= in_data.coord_b[COORD_WIDTH-1:0];
            item_last_reg <= in_data.last_element;
            item_mode_reg <= mode_reg;
        end
        if (cmd.mag_en)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.term_en)
        begin
            term_reg <= term_next;
        end
        if (cmd.root_load)
        begin
            x_reg    <= sum_next;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            x_reg    <= {x_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign stat.item_last = item_last_reg;
    assign stat.item_mode = item_mode_reg;
    assign out_data       = out_reg;

`ifndef ASSERT_OFF
    // A saturated sum is always held at its maximum.
    assert property (@(posedge clk) disable iff (!rst_n) ovf_reg |-> (sum_reg == '1))
        else $error("overflow flag set without a saturated sum");

    // Delivering a result leaves a cleared accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (sum_reg == '0 && !ovf_reg))
        else $error("accumulator not cleared after a result");
`endif

endmodule

`default_nettype wire

### design/vde_ctrl.sv
`default_nettype none

module vde_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire vde_pkg::vde_stat_t stat,
    output vde_pkg::vde_cmd_t       cmd
);
    import vde_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_MUL,
        S_ACC,
        S_ROOT,
        S_FIN
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [ROOT_CNT_W-1:0]  cnt_reg;
    logic [ROOT_CNT_W-1:0]  cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.mag_en = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.term_en = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (!stat.item_last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.item_mode == MODE_EUCLID)
                begin
                    cmd.root_load = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_ROOT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // An accepted item moves straight on to the difference stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.mag_en)
        else $error("accepted item did not reach the difference stage");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    // The square root always starts from its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_load |=> (state_reg == S_ROOT && cnt_reg == '0))
        else $error("square root did not start cleanly");
`endif

endmodule

`default_nettype wire

### design/vector_distance_engine_top.sv
`default_nettype none
// A result is loaded into the output register after the last item's difference,
// multiply and accumulate steps and the final conversion; euclidean results first run
// the square root loop. Items go one at a time through the shared datapath: in_stall
// stays high until an item is through, and a last item also adds the final conversion.
// Reset (rst_n, asynchronous, active low) clears the controller, the output valid flag,
// the running sum, the overflow flag and selects euclidean mode; no clearing pass.

module vector_distance_engine_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire vde_pkg::vde_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output vde_pkg::vde_out_t     out_data
);
    import vde_pkg::*;

    // Commands flow from the controller to the datapath, and the datapath reports
    // the last-item flag and the mode that was captured along with the item.
    vde_cmd_t  cmd;
    vde_stat_t stat;

    // The controller sequences each item through its steps, runs the square root
    // loop for euclidean results and owns the output valid flag, so a finished item
    // can wait in the output register while the next item is already being taken.
    vde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the mode register, the input capture registers, the
    // multiplier, the saturating 64-bit accumulator, the bit-serial square root
    // and the output register.
    vde_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
